>>> rtl/ccss_pkg.sv
// Shared constants, codes and table helpers for the controller-change sweep sequencer.
// No dependencies; imported by the core and its checker.
package ccss_pkg;

  localparam int DefTableDepth = 64;
  localparam int DefRetryTicks = 1000;

  // field widths
  localparam int CtlW    = 7;
  localparam int ValW    = 7;
  localparam int ChW     = 5;
  localparam int TicksW  = 16;
  localparam int CountW  = 7;
  localparam int KindW   = 3;
  localparam int SlotW   = 6;
  localparam int StateW  = 2;
  localparam int StatusW = 3;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 16;

  // input kinds
  localparam logic [KindW-1:0] KIND_TICK  = 3'd0;
  localparam logic [KindW-1:0] KIND_START = 3'd1;
  localparam logic [KindW-1:0] KIND_PAUSE = 3'd2;
  localparam logic [KindW-1:0] KIND_STOP  = 3'd3;
  localparam logic [KindW-1:0] KIND_LOAD  = 3'd4;

  // sweep states
  localparam logic [StateW-1:0] ST_STOPPED = 2'd0;
  localparam logic [StateW-1:0] ST_RUNNING = 2'd1;
  localparam logic [StateW-1:0] ST_PAUSED  = 2'd2;

  // status codes
  localparam logic [StatusW-1:0] STAT_OK          = 3'd0;
  localparam logic [StatusW-1:0] STAT_BLOCKED     = 3'd1;
  localparam logic [StatusW-1:0] STAT_BAD_CHANNEL = 3'd2;
  localparam logic [StatusW-1:0] STAT_BAD_INTERVAL= 3'd3;
  localparam logic [StatusW-1:0] STAT_NO_VALUES   = 3'd4;
  localparam logic [StatusW-1:0] STAT_WAIT_LINK   = 3'd5;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_CONTROL  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FIRST_CH = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LAST_CH  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INTERVAL = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_COUNT    = 3'd4;

  // register reset values
  localparam logic [CtlW-1:0]   RST_CONTROL  = 7'd7;
  localparam logic [ChW-1:0]    RST_FIRST_CH = 5'd1;
  localparam logic [ChW-1:0]    RST_LAST_CH  = 5'd3;
  localparam logic [TicksW-1:0] RST_INTERVAL = 16'd500;
  localparam logic [CountW-1:0] RST_COUNT    = 7'd4;

  localparam logic [ChW-1:0]    MAX_CHANNEL  = 5'd16;
  localparam logic [TicksW-1:0] INTERVAL_MIN = 16'd250;
  localparam logic [TicksW-1:0] INTERVAL_MAX = 16'd60000;

  localparam logic [CtlW-1:0] CTL_BANK_MSB = 7'd0;
  localparam logic [CtlW-1:0] CTL_DATA_MSB = 7'd6;
  localparam logic [CtlW-1:0] CTL_BANK_LSB = 7'd32;
  localparam logic [CtlW-1:0] CTL_DATA_LSB = 7'd38;
  localparam logic [CtlW-1:0] CTL_RPN_LO   = 7'd96;
  localparam logic [CtlW-1:0] CTL_RPN_HI   = 7'd101;
  localparam logic [CtlW-1:0] CTL_MODE_LO  = 7'd120;

  // controllers with a special meaning are refused at start
  function automatic logic ctl_blocked(input logic [CtlW-1:0] c);
    logic r;
    r = (c == CTL_BANK_MSB) || (c == CTL_DATA_MSB) ||
        (c == CTL_BANK_LSB) || (c == CTL_DATA_LSB) ||
        ((c >= CTL_RPN_LO) && (c <= CTL_RPN_HI)) || (c >= CTL_MODE_LO);
    return r;
  endfunction

  // table contents after reset
  function automatic logic [ValW-1:0] tbl_reset_value(input int unsigned idx);
    logic [ValW-1:0] v;
    unique case (idx)
      0:       v = 7'd1;
      1:       v = 7'd32;
      2:       v = 7'd64;
      3:       v = 7'd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/control_change_sweep_sequencer_core.sv
// Controller-change sweep sequencer core: control state, value table memory, output stage.
// Depends on ccss_pkg.
//
// Usage:
//   s_axis: one word per tick or command. tuser carries the kind (tick, start,
//     pause, stop, load); tdata carries link and sink status for ticks and the
//     slot and value for table loads.
//   m_axis: exactly one result word per accepted input word, in order. tuser
//     flags an emitted message, tlast marks the message that ended the sweep.
//   cfg: register writes (index, data), always ready; write only while idle.
// Throughput: one word per cycle while m_axis_tready is high. The value table is
//   a synchronous memory read at accept; its registered read data joins the result
//   in the middle stage, and the result then sits in the output register.
// Output path: an accepted word passes the middle stage and then the output register.
// Stall: with m_axis_tready low the output word holds, one more word is taken
//   into the middle stage, then s_axis_tready drops until the sink drains.
// Reset: registers return to their reset values, the sweep is stopped and the
//   table reads its default contents through per-entry valid bits; no clearing
//   pass, words are accepted as soon as reset is released.
module control_change_sweep_sequencer_core
  import ccss_pkg::*;
#(
  parameter int TABLE_DEPTH = DefTableDepth,
  parameter int RETRY_TICKS = DefRetryTicks
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input words
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,  // link_connected, sink_ready, table_slot[5:0],
                                              // table_value[6:0], zero pad
  input  logic [KindW-1:0]     s_axis_tuser,  // kind[2:0]
  // result words
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata,  // message_control[6:0], message_value[6:0],
                                              // message_channel[4:0], sweep_state[1:0],
                                              // status_code[2:0]
  output logic                 m_axis_tuser,  // message_valid
  output logic                 m_axis_tlast,  // sweep_done
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDatW-1:0]   cfg_data_i
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = (CW > CountW) ? CW : CountW;
  localparam int SW = (CW > SlotW) ? CW : SlotW;
  localparam logic [EW-1:0]     DEPTH_E = EW'(TABLE_DEPTH);
  localparam logic [SW-1:0]     DEPTH_S = SW'(TABLE_DEPTH);
  localparam logic [TicksW-1:0] RETRY   = TicksW'(RETRY_TICKS);

  // input fields
  logic [KindW-1:0] kind;
  logic             link_ok, sink_ok;
  logic [SlotW-1:0] slot;
  logic [ValW-1:0]  tval;
  assign kind    = s_axis_tuser;
  assign link_ok = s_axis_tdata[0];
  assign sink_ok = s_axis_tdata[1];
  assign slot    = s_axis_tdata[7:2];
  assign tval    = s_axis_tdata[14:8];

  // configuration registers
  logic [CtlW-1:0]   control_q, control_d;
  logic [ChW-1:0]    first_q, first_d, last_q, last_d;
  logic [TicksW-1:0] interval_q, interval_d;
  logic [CountW-1:0] count_q, count_d;

  // sweep state
  logic [StateW-1:0] run_q, run_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [ChW-1:0]    ch_q, ch_d;
  logic [TicksW-1:0] ticks_q, ticks_d;
  logic              changed_q, changed_d;

  // pipeline
  logic in_acc, s1_adv;
  logic s1_v_q;
  logic s1_msg_q, s1_msg_d;
  logic s1_done_q, s1_done_d;
  logic [CtlW-1:0]    s1_ctl_q, s1_ctl_d;
  logic [ChW-1:0]     s1_ch_q, s1_ch_d;
  logic [StateW-1:0]  s1_state_q;
  logic [StatusW-1:0] s1_status_q, s1_status_d;
  logic out_v_q;
  logic [23:0] out_data_q;
  logic out_user_q, out_last_q;

  // value table
  logic [ValW-1:0]        tbl_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] tbl_vld_q;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [ValW-1:0]        rd_data_q, rd_rst_q;
  logic                   rd_vld_q;
  logic [ValW-1:0]        msg_value;

  assign s1_adv        = s1_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !s1_v_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // sweep control
  logic [TicksW-1:0] ticks_dec;
  logic [EW-1:0]     eff_count, pos_inc;
  logic [ChW-1:0]    lim, ch_inc;
  logic [SW-1:0]     slot_ext;
  logic              slot_ok;

  always_comb begin
    ticks_dec = (ticks_q != '0) ? ticks_q - 1'b1 : '0;
    eff_count = (EW'(count_q) > DEPTH_E) ? DEPTH_E : EW'(count_q);
    pos_inc   = EW'(pos_q) + 1'b1;
    lim       = (last_q < MAX_CHANNEL) ? last_q : MAX_CHANNEL;
    ch_inc    = ch_q + 1'b1;
    slot_ext  = SW'(slot);
    slot_ok   = slot_ext < DEPTH_S;
    wr_addr   = slot_ext[AW-1:0];
  end

  always_comb begin
    run_d       = run_q;
    pos_d       = pos_q;
    ch_d        = ch_q;
    ticks_d     = ticks_q;
    changed_d   = changed_q;
    s1_msg_d    = 1'b0;
    s1_done_d   = 1'b0;
    s1_ctl_d    = '0;
    s1_ch_d     = '0;
    s1_status_d = STAT_OK;
    wr_en       = 1'b0;
    if (in_acc) begin
      unique case (kind)
        KIND_TICK: begin
          if (run_q == ST_RUNNING) begin
            ticks_d = ticks_dec;
            if (ticks_dec == '0) begin
              if (!link_ok) begin
                ticks_d     = RETRY;
                s1_status_d = STAT_WAIT_LINK;
              end else if (!sink_ok) begin
                ticks_d = RETRY;
              end else begin
                s1_msg_d = 1'b1;
                s1_ctl_d = control_q;
                s1_ch_d  = ch_q;
                ticks_d  = interval_q;
                pos_d    = pos_inc[AW-1:0];
                if (pos_inc >= eff_count) begin
                  pos_d = '0;
                  ch_d  = ch_inc;
                  if (ch_inc == '0 || ch_inc > lim) begin
                    run_d     = ST_STOPPED;
                    s1_done_d = 1'b1;
                  end
                end
              end
            end
          end
        end
        KIND_START: begin
          priority if (run_q == ST_PAUSED && !changed_q) begin
            run_d   = ST_RUNNING;
            ticks_d = '0;
          end else if (ctl_blocked(control_q)) begin
            s1_status_d = STAT_BLOCKED;
          end else if (first_q == '0 || first_q > MAX_CHANNEL ||
                       last_q < first_q || last_q > MAX_CHANNEL) begin
            s1_status_d = STAT_BAD_CHANNEL;
          end else if (interval_q < INTERVAL_MIN || interval_q > INTERVAL_MAX) begin
            s1_status_d = STAT_BAD_INTERVAL;
          end else if (count_q == '0) begin
            s1_status_d = STAT_NO_VALUES;
          end else begin
            changed_d = 1'b0;
            ch_d      = first_q;
            pos_d     = '0;
            ticks_d   = '0;
            run_d     = ST_RUNNING;
          end
        end
        KIND_PAUSE: begin
          if (run_q == ST_RUNNING) run_d = ST_PAUSED;
        end
        KIND_STOP: begin
          run_d = ST_STOPPED;
          pos_d = '0;
          ch_d  = first_q;
        end
        KIND_LOAD: begin
          wr_en     = slot_ok;
          changed_d = 1'b1;
        end
        default: ;
      endcase
    end
    if (cfg_valid_i && cfg_index_i <= REG_COUNT) changed_d = 1'b1;
  end

  always_comb begin
    control_d  = control_q;
    first_d    = first_q;
    last_d     = last_q;
    interval_d = interval_q;
    count_d    = count_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CONTROL:  control_d  = cfg_data_i[CtlW-1:0];
        REG_FIRST_CH: first_d    = cfg_data_i[ChW-1:0];
        REG_LAST_CH:  last_d     = cfg_data_i[ChW-1:0];
        REG_INTERVAL: interval_d = cfg_data_i[TicksW-1:0];
        REG_COUNT:    count_d    = cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_q  <= RST_CONTROL;
      first_q    <= RST_FIRST_CH;
      last_q     <= RST_LAST_CH;
      interval_q <= RST_INTERVAL;
      count_q    <= RST_COUNT;
      run_q      <= ST_STOPPED;
      pos_q      <= '0;
      ch_q       <= ChW'(1);
      ticks_q    <= '0;
      changed_q  <= 1'b0;
      tbl_vld_q  <= '0;
      s1_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      control_q  <= control_d;
      first_q    <= first_d;
      last_q     <= last_d;
      interval_q <= interval_d;
      count_q    <= count_d;
      run_q      <= run_d;
      pos_q      <= pos_d;
      ch_q       <= ch_d;
      ticks_q    <= ticks_d;
      changed_q  <= changed_d;
      if (wr_en) tbl_vld_q[wr_addr] <= 1'b1;
      if (in_acc)      s1_v_q <= 1'b1;
      else if (s1_adv) s1_v_q <= 1'b0;
      if (s1_adv)             out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  // table memory: write on load, read the current position on every accepted word;
  // read data holds until the next accept, which keeps it aligned with the middle stage
  always_ff @(posedge clk_i) begin
    if (wr_en) tbl_mem[wr_addr] <= tval;
    if (in_acc) begin
      rd_data_q <= tbl_mem[pos_q];
      rd_vld_q  <= tbl_vld_q[pos_q];
      rd_rst_q  <= tbl_reset_value(int'(pos_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_msg_q    <= s1_msg_d;
      s1_done_q   <= s1_done_d;
      s1_ctl_q    <= s1_ctl_d;
      s1_ch_q     <= s1_ch_d;
      s1_state_q  <= run_d;
      s1_status_q <= s1_status_d;
    end
  end

  assign msg_value = !s1_msg_q ? '0 : (rd_vld_q ? rd_data_q : rd_rst_q);

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= {s1_status_q, s1_state_q, s1_ch_q, msg_value, s1_ctl_q};
      out_user_q <= s1_msg_q;
      out_last_q <= s1_done_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

>>> rtl/ccss_checker.sv
// Port-level checker for the sweep sequencer core, bound to the core module.
// Depends on ccss_pkg and control_change_sweep_sequencer_core.
module ccss_checker
  import ccss_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  // no message: message fields are zero and the sweep cannot end
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[18:0] == '0 && !m_axis_tlast)
    else $error("message fields set without a message");

  // the final message leaves the sweep stopped
  a_done_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[20:19] == ST_STOPPED &&
      m_axis_tdata[23:21] == STAT_OK)
    else $error("sweep end reported while not stopped");

  // a message always carries a valid channel and ok status
  a_msg_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[18:14] != '0 &&
      m_axis_tdata[18:14] <= MAX_CHANNEL && m_axis_tdata[23:21] == STAT_OK)
    else $error("message with bad channel or status");

endmodule

bind control_change_sweep_sequencer_core ccss_checker u_ccss_checker (.*);
